>>> src/spt_pkg.sv
// shared types, codes and constants for the sampling parameter tuner
// no dependencies; used by every module of the block and by the checker
package spt_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;

  // configuration register indexes
  localparam logic [2:0] REG_RUN_MODE     = 3'd0;
  localparam logic [2:0] REG_STRATEGY     = 3'd1;
  localparam logic [2:0] REG_TEMP_FLOOR   = 3'd2;
  localparam logic [2:0] REG_TEMP_CEILING = 3'd3;
  localparam logic [2:0] REG_TOPK_FLOOR   = 3'd4;
  localparam logic [2:0] REG_TOPK_CEILING = 3'd5;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_OBSERVE = 2'd1;
  localparam logic [1:0] MODE_ENFORCE = 2'd2;

  localparam logic [2:0] STRAT_NONE    = 3'd0;
  localparam logic [2:0] STRAT_ENTROPY = 3'd1;
  localparam logic [2:0] STRAT_LENGTH  = 3'd2;
  localparam logic [2:0] STRAT_QUALITY = 3'd3;
  localparam logic [2:0] STRAT_HYBRID  = 3'd4;

  localparam logic [15:0] SHORT_LIMIT   = 16'd32;
  localparam logic [15:0] LONG_LIMIT    = 16'd128;
  localparam logic [15:0] ENT_LOW       = 16'd400;
  localparam logic [15:0] ENT_HIGH      = 16'd1600;
  localparam logic [15:0] ENT_HYBRID    = 16'd450;
  localparam logic [15:0] REP_QUALITY   = 16'd2;
  localparam logic [15:0] REP_HYBRID    = 16'd1;

  localparam logic [12:0] TEMP_STEP_ENT  = 13'd40;
  localparam logic [12:0] TEMP_STEP_LEN  = 13'd25;
  localparam logic [12:0] TEMP_STEP_QUAL = 13'd120;
  localparam logic [12:0] TEMP_STEP_HYB  = 13'd60;
  localparam logic [12:0] TEMP_DEC_MIN   = 13'd200;
  localparam logic [12:0] STEP_LIMIT     = 13'd100;

  localparam logic [8:0] TOPK_STEP_LEN  = 9'd2;
  localparam logic [8:0] TOPK_STEP_QUAL = 9'd15;
  localparam logic [8:0] TOPK_DEC_MIN   = 9'd10;

  localparam logic [11:0] TEMP_RESET       = 12'd800;
  localparam logic [7:0]  TOPK_RESET       = 8'd40;
  localparam logic [9:0]  TOP_P_FIXED      = 10'd900;
  localparam logic [11:0] TEMP_FLOOR_RST   = 12'd100;
  localparam logic [11:0] TEMP_CEILING_RST = 12'd2000;
  localparam logic [7:0]  TOPK_FLOOR_RST   = 8'd1;
  localparam logic [7:0]  TOPK_CEILING_RST = 8'd100;

  typedef struct packed {
    logic [15:0] token_count;
    logic [15:0] repeat_count;
    logic [15:0] entropy_sample;
  } spt_in_t;

  typedef struct packed {
    logic [11:0] temp_milli;
    logic [7:0]  top_k;
    logic [9:0]  top_p_milli;
    logic [15:0] avg_entropy;
    logic [31:0] adjust_count;
  } spt_out_t;

  typedef struct packed {
    logic [1:0]  run_mode;
    logic [2:0]  strategy_select;
    logic [11:0] temp_floor;
    logic [11:0] temp_ceiling;
    logic [7:0]  topk_floor;
    logic [7:0]  topk_ceiling;
  } spt_cfg_t;

  typedef struct packed {
    logic [11:0] temp;
    logic [7:0]  topk;
    logic [15:0] avg;
  } spt_rec_t;

endpackage

>>> src/spt_update.sv
// next-state logic: statistics, strategy adjustment, step limit and clamp
// depends on spt_pkg
module spt_update #(
  parameter int unsigned COUNT_BITS = spt_pkg::COUNT_BITS_DEF
) (
  input  spt_pkg::spt_cfg_t      cfg,
  input  spt_pkg::spt_in_t       item,
  input  spt_pkg::spt_rec_t      rec,
  input  logic [COUNT_BITS-1:0]  sample_cnt,
  input  logic [COUNT_BITS-1:0]  short_cnt,
  input  logic [COUNT_BITS-1:0]  long_cnt,
  input  logic [COUNT_BITS-1:0]  update_cnt,
  output spt_pkg::spt_rec_t      rec_nxt,
  output logic [COUNT_BITS-1:0]  sample_cnt_nxt,
  output logic [COUNT_BITS-1:0]  short_cnt_nxt,
  output logic [COUNT_BITS-1:0]  long_cnt_nxt,
  output logic [COUNT_BITS-1:0]  update_cnt_nxt
);

  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic        active;
  logic        enforce;
  logic [18:0] avg_sum;
  logic [15:0] avg_new;
  logic [12:0] old_t;
  logic [12:0] t_adj;
  logic [12:0] t_lim;
  logic [12:0] t_flr;
  logic [12:0] t_clp;
  logic [8:0]  k_adj;
  logic [8:0]  k_flr;
  logic [8:0]  k_clp;

  always_comb begin
    active  = (cfg.run_mode != spt_pkg::MODE_OFF);
    enforce = (cfg.run_mode == spt_pkg::MODE_ENFORCE);

    sample_cnt_nxt = sample_cnt;
    short_cnt_nxt  = short_cnt;
    long_cnt_nxt   = long_cnt;
    update_cnt_nxt = update_cnt;
    rec_nxt        = rec;

    // running average: (avg*7 + x) / 8
    avg_sum = {rec.avg, 3'b000} - {3'b000, rec.avg} + {3'b000, item.entropy_sample};
    avg_new = rec.avg;

    if (active) begin
      sample_cnt_nxt = sample_cnt + CNT_ONE;
      if (sample_cnt_nxt == CNT_ONE) begin
        avg_new = item.entropy_sample;
      end else begin
        avg_new = avg_sum[18:3];
      end
      if (item.token_count < spt_pkg::SHORT_LIMIT) begin
        short_cnt_nxt = short_cnt + CNT_ONE;
      end else if (item.token_count > spt_pkg::LONG_LIMIT) begin
        long_cnt_nxt = long_cnt + CNT_ONE;
      end
      rec_nxt.avg = avg_new;
    end

    old_t = {1'b0, rec.temp};
    t_adj = old_t;
    k_adj = {1'b0, rec.topk};
    case (cfg.strategy_select)
      spt_pkg::STRAT_ENTROPY: begin
        if (avg_new < spt_pkg::ENT_LOW) begin
          t_adj = old_t + spt_pkg::TEMP_STEP_ENT;
        end else if (avg_new > spt_pkg::ENT_HIGH && old_t > spt_pkg::TEMP_DEC_MIN) begin
          t_adj = old_t - spt_pkg::TEMP_STEP_ENT;
        end
      end
      spt_pkg::STRAT_LENGTH: begin
        if (short_cnt_nxt > long_cnt_nxt) begin
          t_adj = old_t + spt_pkg::TEMP_STEP_LEN;
          k_adj = {1'b0, rec.topk} + spt_pkg::TOPK_STEP_LEN;
        end else if (long_cnt_nxt > short_cnt_nxt) begin
          if (old_t > spt_pkg::TEMP_DEC_MIN) begin
            t_adj = old_t - spt_pkg::TEMP_STEP_LEN;
          end
          if ({1'b0, rec.topk} > spt_pkg::TOPK_DEC_MIN) begin
            k_adj = {1'b0, rec.topk} - spt_pkg::TOPK_STEP_LEN;
          end
        end
      end
      spt_pkg::STRAT_QUALITY: begin
        if (item.repeat_count > spt_pkg::REP_QUALITY) begin
          t_adj = old_t + spt_pkg::TEMP_STEP_QUAL;
          k_adj = {1'b0, rec.topk} + spt_pkg::TOPK_STEP_QUAL;
        end
      end
      spt_pkg::STRAT_HYBRID: begin
        if (avg_new < spt_pkg::ENT_HYBRID || item.repeat_count > spt_pkg::REP_HYBRID) begin
          t_adj = old_t + spt_pkg::TEMP_STEP_HYB;
        end
      end
      default: begin
      end
    endcase

    // step limit
    t_lim = t_adj;
    if (t_adj > old_t && (t_adj - old_t) > spt_pkg::STEP_LIMIT) begin
      t_lim = old_t + spt_pkg::STEP_LIMIT;
    end else if (old_t > t_adj && (old_t - t_adj) > spt_pkg::STEP_LIMIT) begin
      t_lim = old_t - spt_pkg::STEP_LIMIT;
    end

    // floor first, then ceiling
    t_flr = (t_lim < {1'b0, cfg.temp_floor}) ? {1'b0, cfg.temp_floor} : t_lim;
    t_clp = (t_flr > {1'b0, cfg.temp_ceiling}) ? {1'b0, cfg.temp_ceiling} : t_flr;
    k_flr = (k_adj < {1'b0, cfg.topk_floor}) ? {1'b0, cfg.topk_floor} : k_adj;
    k_clp = (k_flr > {1'b0, cfg.topk_ceiling}) ? {1'b0, cfg.topk_ceiling} : k_flr;

    if (active && enforce) begin
      rec_nxt.temp   = t_clp[11:0];
      rec_nxt.topk   = k_clp[7:0];
      update_cnt_nxt = update_cnt + CNT_ONE;
    end
  end

endmodule

>>> src/sampling_parameter_tuner.sv
// sampling parameter tuner top level: config registers, input and result registers
// request registered in in_r, result registered in out_r; one request per cycle sustained while out_stall is low
// depends on spt_pkg and spt_update
// reset (rst_n low, synchronous) empties both stages, loads the config defaults,
// clears the counters and average and sets temperature 800, top-k 40
module sampling_parameter_tuner #(
  parameter int unsigned COUNT_BITS = spt_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spt_pkg::spt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spt_pkg::spt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [11:0]       cfg_wdata
);

  spt_pkg::spt_cfg_t  cfg_r;
  spt_pkg::spt_in_t   in_r;
  logic               in_vld_r;
  logic               in_vld_nxt;
  spt_pkg::spt_out_t  out_r;
  logic               out_vld_r;
  logic               out_vld_nxt;
  spt_pkg::spt_rec_t  rec_r;
  spt_pkg::spt_rec_t  rec_nxt;
  logic [COUNT_BITS-1:0] sample_cnt_r;
  logic [COUNT_BITS-1:0] sample_cnt_nxt;
  logic [COUNT_BITS-1:0] short_cnt_r;
  logic [COUNT_BITS-1:0] short_cnt_nxt;
  logic [COUNT_BITS-1:0] long_cnt_r;
  logic [COUNT_BITS-1:0] long_cnt_nxt;
  logic [COUNT_BITS-1:0] update_cnt_r;
  logic [COUNT_BITS-1:0] update_cnt_nxt;
  logic [31:0]        adj_count;
  logic               out_free;
  logic               go;
  logic               in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || !out_stall;
  assign go        = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  assign in_vld_nxt  = in_take || (in_vld_r && !go);
  assign out_vld_nxt = go || (out_vld_r && out_stall);

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  spt_update #(
    .COUNT_BITS(COUNT_BITS)
  ) u_update (
    .cfg            (cfg_r),
    .item           (in_r),
    .rec            (rec_r),
    .sample_cnt     (sample_cnt_r),
    .short_cnt      (short_cnt_r),
    .long_cnt       (long_cnt_r),
    .update_cnt     (update_cnt_r),
    .rec_nxt        (rec_nxt),
    .sample_cnt_nxt (sample_cnt_nxt),
    .short_cnt_nxt  (short_cnt_nxt),
    .long_cnt_nxt   (long_cnt_nxt),
    .update_cnt_nxt (update_cnt_nxt)
  );

  if (COUNT_BITS >= 32) begin : g_cnt_wide
    assign adj_count = update_cnt_nxt[31:0];
  end else begin : g_cnt_narrow
    assign adj_count = {{(32-COUNT_BITS){1'b0}}, update_cnt_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_mode        <= spt_pkg::MODE_OFF;
      cfg_r.strategy_select <= spt_pkg::STRAT_NONE;
      cfg_r.temp_floor      <= spt_pkg::TEMP_FLOOR_RST;
      cfg_r.temp_ceiling    <= spt_pkg::TEMP_CEILING_RST;
      cfg_r.topk_floor      <= spt_pkg::TOPK_FLOOR_RST;
      cfg_r.topk_ceiling    <= spt_pkg::TOPK_CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spt_pkg::REG_RUN_MODE:     cfg_r.run_mode        <= cfg_wdata[1:0];
        spt_pkg::REG_STRATEGY:     cfg_r.strategy_select <= cfg_wdata[2:0];
        spt_pkg::REG_TEMP_FLOOR:   cfg_r.temp_floor      <= cfg_wdata;
        spt_pkg::REG_TEMP_CEILING: cfg_r.temp_ceiling    <= cfg_wdata;
        spt_pkg::REG_TOPK_FLOOR:   cfg_r.topk_floor      <= cfg_wdata[7:0];
        spt_pkg::REG_TOPK_CEILING: cfg_r.topk_ceiling    <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.temp   <= spt_pkg::TEMP_RESET;
      rec_r.topk   <= spt_pkg::TOPK_RESET;
      rec_r.avg    <= '0;
      sample_cnt_r <= '0;
      short_cnt_r  <= '0;
      long_cnt_r   <= '0;
      update_cnt_r <= '0;
    end else if (go) begin
      rec_r        <= rec_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      short_cnt_r  <= short_cnt_nxt;
      long_cnt_r   <= long_cnt_nxt;
      update_cnt_r <= update_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (go) begin
      out_r.temp_milli   <= rec_nxt.temp;
      out_r.top_k        <= rec_nxt.topk;
      out_r.top_p_milli  <= spt_pkg::TOP_P_FIXED;
      out_r.avg_entropy  <= rec_nxt.avg;
      out_r.adjust_count <= adj_count;
    end
  end

endmodule

>>> src/spt_checker.sv
// port-level checks for the sampling parameter tuner, bound to the top level
// depends on spt_pkg and sampling_parameter_tuner
module spt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input spt_pkg::spt_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_top_p: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.top_p_milli == spt_pkg::TOP_P_FIXED)
    else $error("top-p not fixed");

  // consecutive results differ by at most one enforce update
  a_adj_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall ##1 out_valid |->
      (out_data.adjust_count == $past(out_data.adjust_count)) ||
      (out_data.adjust_count == $past(out_data.adjust_count) + 32'd1))
    else $error("update count jumped");

endmodule

bind sampling_parameter_tuner spt_checker u_spt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
